### src/fcfs_pkg.sv
// ----------------------------------------------------------------------------
// fcfs_pkg
// shared types and codes for the fcfs scheduler with i/o wait list
// ----------------------------------------------------------------------------
package fcfs_pkg;

  // input operation codes
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_KILL = 2'd1,
    OP_TICK = 2'd2,
    OP_ALT  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_KILLSET = 3'd1,
    ST_DUP     = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_REJECT  = 3'd4,
    ST_RAN     = 3'd5,
    ST_IDLE    = 3'd6,
    ST_SPARE   = 3'd7
  } status_t;

  // one task table record
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] burst;
    logic [15:0] io_start;
    logic [15:0] io_left;
    logic [15:0] run;
    logic [15:0] kill;
  } rec_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    scan_rd;
    logic    scan_next;
    logic    kill_wr;
    logic    add_wr;
    logic    st_set;
    status_t st_code;
    logic    disp_rd;
    logic    disp_take;
    logic    tick_adv;
    logic    run_upd;
    logic    walk_clr;
    logic    walk_rd;
    logic    walk_rd2;
    logic    walk_upd;
    logic    walk_fin;
    logic    out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_t  op;
    logic scan_end;
    logic match;
    logic add_bad;
    logic need_disp;
    logic idle;
    logic cur_v;
    logic walk_end;
    logic out_busy;
  } stat_t;

endpackage

### src/fcfs_ctrl.sv
// ----------------------------------------------------------------------------
// fcfs_ctrl
// sequencing state machine for add, kill and tick transactions
// ----------------------------------------------------------------------------
module fcfs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  fcfs_pkg::stat_t st,
  output fcfs_pkg::cmd_t  cmd
);
  import fcfs_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SCAN  = 12'b000000000010,
    S_SCMP  = 12'b000000000100,
    S_DISP  = 12'b000000001000,
    S_DTAKE = 12'b000000010000,
    S_TCHK  = 12'b000000100000,
    S_TRUN  = 12'b000001000000,
    S_WCLR  = 12'b000010000000,
    S_WRD   = 12'b000100000000,
    S_WRD2  = 12'b001000000000,
    S_WUPD  = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.st_code = ST_ADDED;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_SCAN: begin
        if (st.scan_end) begin
          cmd.st_set = 1'b1;
          state_nxt = S_DONE;
          if (st.op == OP_ADD) begin
            if (st.add_bad) begin
              cmd.st_code = ST_REJECT;
            end else begin
              cmd.add_wr = 1'b1;
              cmd.st_code = ST_ADDED;
            end
          end else begin
            cmd.st_code = ST_UNKNOWN;
          end
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (st.match) begin
          cmd.st_set = 1'b1;
          state_nxt = S_DONE;
          if (st.op == OP_ADD) begin
            cmd.st_code = ST_DUP;
          end else begin
            cmd.kill_wr = 1'b1;
            cmd.st_code = ST_KILLSET;
          end
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_DISP: begin
        if (st.op == OP_ADD || st.op == OP_KILL) begin
          state_nxt = S_SCAN;
        end else if (st.need_disp) begin
          cmd.disp_rd = 1'b1;
          state_nxt = S_DTAKE;
        end else begin
          state_nxt = S_TCHK;
        end
      end
      S_DTAKE: begin
        cmd.disp_take = 1'b1;
        state_nxt = S_TCHK;
      end
      S_TCHK: begin
        if (st.idle) begin
          cmd.st_set = 1'b1;
          cmd.st_code = ST_IDLE;
          state_nxt = S_DONE;
        end else begin
          cmd.tick_adv = 1'b1;
          cmd.st_set = 1'b1;
          cmd.st_code = ST_RAN;
          state_nxt = st.cur_v ? S_TRUN : S_WCLR;
        end
      end
      S_TRUN: begin
        cmd.run_upd = 1'b1;
        state_nxt = S_WCLR;
      end
      S_WCLR: begin
        cmd.walk_clr = 1'b1;
        state_nxt = S_WRD;
      end
      S_WRD: begin
        if (st.walk_end) begin
          cmd.walk_fin = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt = S_WRD2;
        end
      end
      S_WRD2: begin
        cmd.walk_rd2 = 1'b1;
        state_nxt = S_WUPD;
      end
      S_WUPD: begin
        cmd.walk_upd = 1'b1;
        state_nxt = S_WRD;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### src/fcfs_dp.sv
// ----------------------------------------------------------------------------
// fcfs_dp
// task table, ready queue, wait list, time and result registers
// ----------------------------------------------------------------------------
module fcfs_dp #(
  parameter int MAX_TASKS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fcfs_pkg::cmd_t        cmd,
  output fcfs_pkg::stat_t       st,
  input  logic [1:0]            in_op,
  input  logic [15:0]           in_task_id,
  input  logic [15:0]           in_burst_time,
  input  logic [15:0]           in_io_start,
  input  logic [15:0]           in_io_length,
  input  logic [15:0]           in_kill_at,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic                  out_done_valid,
  output logic [15:0]           out_done_id,
  output logic                  out_done_killed,
  output logic [31:0]           out_done_time,
  output logic [31:0]           out_wait_time,
  output logic                  out_running_valid,
  output logic [15:0]           out_running_id
);
  import fcfs_pkg::*;

  localparam int SW = (MAX_TASKS > 2) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = SW + 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_TASKS);
  localparam logic [SW-1:0] LASTS = SW'(MAX_TASKS - 1);

  // memories
  rec_t          tmem [MAX_TASKS];
  logic [SW-1:0] rq   [MAX_TASKS];
  logic [SW-1:0] wl   [MAX_TASKS];

  // latched item
  op_t         op_r;
  logic [15:0] id_r, burst_r, iost_r, iolen_r, kill_r;

  // control registers
  logic [CW-1:0] count_r, rfill_r, wfill_r, idx_r, w_r, n_r;
  logic [SW-1:0] rhead_r, cur_r, slot_r;
  logic          cur_v_r;
  logic [15:0]   cur_id_r;
  logic [31:0]   time_r;

  // read data
  rec_t          trd_r;
  logic [SW-1:0] qrd_r, wrd_r;

  // result and output registers
  status_t     res_st_r;
  logic        res_dv_r, res_dk_r;
  logic [15:0] res_did_r;
  logic [31:0] res_dt_r, res_dw_r;
  logic        ov_r;

  // ready tail index, modulo table size
  logic [CW:0]   tail_sum;
  logic [SW-1:0] tail;
  always_comb begin
    tail_sum = {2'b00, rhead_r} + {1'b0, rfill_r};
    if (tail_sum >= {1'b0, MAXC}) begin
      tail_sum = tail_sum - {1'b0, MAXC};
    end
    tail = tail_sum[SW-1:0];
  end

  // run tick decisions
  logic [15:0] run_new;
  logic        kill_hit, io_hit, fin_hit;
  assign run_new  = trd_r.run + 16'd1;
  assign kill_hit = (trd_r.kill != 16'd0) && (run_new == trd_r.kill);
  assign io_hit   = (trd_r.io_start != 16'd0) && (run_new == trd_r.io_start) &&
                    (trd_r.io_left != 16'd0);
  assign fin_hit  = (run_new >= trd_r.burst);

  // task table write and read port selection
  logic          t_we;
  logic [SW-1:0] t_wa;
  rec_t          t_wd;
  logic          t_re;
  logic [SW-1:0] t_ra;
  always_comb begin
    t_we = 1'b0;
    t_wa = idx_r[SW-1:0];
    t_wd = trd_r;
    if (cmd.kill_wr) begin
      t_we = 1'b1;
      t_wd.kill = kill_r;
    end else if (cmd.add_wr) begin
      t_we = 1'b1;
      t_wa = count_r[SW-1:0];
      t_wd = '{id: id_r, burst: burst_r, io_start: iost_r, io_left: iolen_r,
               run: 16'd0, kill: 16'd0};
    end else if (cmd.run_upd) begin
      t_we = 1'b1;
      t_wa = cur_r;
      t_wd.run = run_new;
    end else if (cmd.walk_upd && trd_r.io_left != 16'd0) begin
      t_we = 1'b1;
      t_wa = slot_r;
      t_wd.io_left = trd_r.io_left - 16'd1;
    end
    t_re = cmd.scan_rd | cmd.tick_adv | cmd.walk_rd2;
    t_ra = cmd.scan_rd ? idx_r[SW-1:0] : (cmd.tick_adv ? cur_r : wrd_r);
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_wa] <= t_wd;
    end
    if (t_re) begin
      trd_r <= tmem[t_ra];
    end
  end

  // ready queue memory
  logic          q_we;
  logic [SW-1:0] q_wd;
  assign q_we = (cmd.add_wr || (cmd.walk_upd && trd_r.io_left == 16'd0)) &&
                (rfill_r < MAXC);
  assign q_wd = cmd.add_wr ? count_r[SW-1:0] : slot_r;

  always_ff @(posedge clk) begin
    if (q_we) begin
      rq[tail] <= q_wd;
    end
    if (cmd.disp_rd) begin
      qrd_r <= rq[rhead_r];
    end
  end

  // wait list memory
  logic          w_we;
  logic [SW-1:0] w_wa, w_wd;
  always_comb begin
    w_we = 1'b0;
    w_wa = wfill_r[SW-1:0];
    w_wd = cur_r;
    if (cmd.run_upd && !kill_hit && io_hit && wfill_r < MAXC) begin
      w_we = 1'b1;
    end else if (cmd.walk_upd && trd_r.io_left != 16'd0) begin
      w_we = 1'b1;
      w_wa = w_r[SW-1:0];
      w_wd = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wl[w_wa] <= w_wd;
    end
    if (cmd.walk_rd) begin
      wrd_r <= wl[idx_r[SW-1:0]];
    end
  end

  // latched item and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= op_t'(in_op);
      id_r      <= in_task_id;
      burst_r   <= in_burst_time;
      iost_r    <= in_io_start;
      iolen_r   <= in_io_length;
      kill_r    <= in_kill_at;
      res_dv_r  <= 1'b0;
      res_dk_r  <= 1'b0;
      res_did_r <= 16'd0;
      res_dt_r  <= 32'd0;
      res_dw_r  <= 32'd0;
    end
    if (cmd.st_set) begin
      res_st_r <= cmd.st_code;
    end
    if (cmd.walk_rd2) begin
      slot_r <= wrd_r;
    end
    if (cmd.run_upd) begin
      cur_id_r <= trd_r.id;
      if (kill_hit) begin
        res_dv_r  <= 1'b1;
        res_dk_r  <= 1'b1;
        res_did_r <= trd_r.id;
        res_dt_r  <= {16'd0, run_new};
      end else if (!io_hit && fin_hit) begin
        res_dv_r  <= 1'b1;
        res_did_r <= trd_r.id;
        res_dt_r  <= time_r;
        res_dw_r  <= time_r - {16'd0, trd_r.burst};
      end
    end
    if (cmd.out_load) begin
      out_status        <= res_st_r;
      out_done_valid    <= res_dv_r;
      out_done_id       <= res_did_r;
      out_done_killed   <= res_dk_r;
      out_done_time     <= res_dt_r;
      out_wait_time     <= res_dw_r;
      out_running_valid <= cur_v_r;
      out_running_id    <= cur_v_r ? cur_id_r : 16'd0;
    end
  end

  // scheduler control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rfill_r <= '0;
      wfill_r <= '0;
      rhead_r <= '0;
      cur_r   <= '0;
      cur_v_r <= 1'b0;
      time_r  <= 32'd0;
      idx_r   <= '0;
      w_r     <= '0;
      n_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cmd.load || cmd.walk_clr) begin
        idx_r <= '0;
      end else if (cmd.scan_next || cmd.walk_upd) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.add_wr) begin
        count_r <= count_r + CW'(1);
      end
      if (q_we) begin
        rfill_r <= rfill_r + CW'(1);
      end
      if (cmd.disp_take) begin
        cur_r   <= qrd_r;
        cur_v_r <= 1'b1;
        rhead_r <= (rhead_r == LASTS) ? '0 : rhead_r + SW'(1);
        rfill_r <= rfill_r - CW'(1);
      end
      if (cmd.tick_adv) begin
        time_r <= time_r + 32'd1;
      end
      if (cmd.run_upd) begin
        if (kill_hit || io_hit || fin_hit) begin
          cur_v_r <= 1'b0;
        end
        if (!kill_hit && io_hit && wfill_r < MAXC) begin
          wfill_r <= wfill_r + CW'(1);
        end
      end
      if (cmd.walk_clr) begin
        w_r <= '0;
        n_r <= wfill_r;
      end
      if (cmd.walk_upd && trd_r.io_left != 16'd0) begin
        w_r <= w_r + CW'(1);
      end
      if (cmd.walk_fin) begin
        wfill_r <= w_r;
      end
      if (cmd.out_load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid = ov_r;

  // status to the controller
  always_comb begin
    st.op        = op_r;
    st.scan_end  = (idx_r == count_r);
    st.match     = (trd_r.id == id_r);
    st.add_bad   = (burst_r == 16'd0) || (count_r >= MAXC);
    st.need_disp = !cur_v_r && (rfill_r != '0);
    st.idle      = !cur_v_r && (rfill_r == '0) && (wfill_r == '0);
    st.cur_v     = cur_v_r;
    st.walk_end  = (idx_r == n_r);
    st.out_busy  = ov_r && !out_ready;
  end

endmodule

### src/fcfs_scheduler_with_io_wait_top.sv
// add and kill scan the table serially; a tick dispatches from the ready queue
// when no task runs, advances the running task, then walks the i/o wait list
// serially over single-port table, queue and list memories; an idle tick skips
// the run and the walk
// one transaction at a time; input is taken again once the result is registered
// reset: synchronous active-low rst_n empties the table, queues and time
// ----------------------------------------------------------------------------
// fcfs_scheduler_with_io_wait_top
// first-come first-served task scheduler with an i/o wait list
// ----------------------------------------------------------------------------
module fcfs_scheduler_with_io_wait_top #(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_task_id,
  input  logic [15:0] in_burst_time,
  input  logic [15:0] in_io_start,
  input  logic [15:0] in_io_length,
  input  logic [15:0] in_kill_at,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_done_valid,
  output logic [15:0] out_done_id,
  output logic        out_done_killed,
  output logic [31:0] out_done_time,
  output logic [31:0] out_wait_time,
  output logic        out_running_valid,
  output logic [15:0] out_running_id
);
  import fcfs_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // controller
  fcfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath
  fcfs_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_op             (in_op),
    .in_task_id        (in_task_id),
    .in_burst_time     (in_burst_time),
    .in_io_start       (in_io_start),
    .in_io_length      (in_io_length),
    .in_kill_at        (in_kill_at),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_done_valid    (out_done_valid),
    .out_done_id       (out_done_id),
    .out_done_killed   (out_done_killed),
    .out_done_time     (out_done_time),
    .out_wait_time     (out_wait_time),
    .out_running_valid (out_running_valid),
    .out_running_id    (out_running_id)
  );

endmodule

### sim/tb_fcfs_scheduler_with_io_wait_top.sv
// ----------------------------------------------------------------------------
// tb_fcfs_scheduler_with_io_wait_top
// self-checking bench for the fcfs scheduler: directed corner cases, then
// random add/kill/alt/tick traffic under several idle and stall mixes
// ----------------------------------------------------------------------------
module tb_fcfs_scheduler_with_io_wait_top;
  import fcfs_pkg::*;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    status_t     status;
    logic        done_valid;
    logic [15:0] done_id;
    logic        done_killed;
    logic [31:0] done_time;
    logic [31:0] wait_time;
    logic        running_valid;
    logic [15:0] running_id;
  } sched_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [15:0] in_task_id;
  logic [15:0] in_burst_time;
  logic [15:0] in_io_start;
  logic [15:0] in_io_length;
  logic [15:0] in_kill_at;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic        out_done_valid;
  logic [15:0] out_done_id;
  logic        out_done_killed;
  logic [31:0] out_done_time;
  logic [31:0] out_wait_time;
  logic        out_running_valid;
  logic [15:0] out_running_id;

  fcfs_scheduler_with_io_wait_top #(.MAX_TASKS(NSLOT)) dut (.*);

  // scheduler mirror state
  logic [15:0] m_id[NSLOT];
  logic [15:0] m_burst[NSLOT];
  logic [15:0] m_io_start[NSLOT];
  logic [15:0] m_io_left[NSLOT];
  logic [15:0] m_run[NSLOT];
  logic [15:0] m_kill[NSLOT];
  bit          m_used[NSLOT];
  int          m_count;
  int          m_ready_q[NSLOT];
  int          m_ready_head;
  int          m_ready_fill;
  int          m_wait_q[NSLOT];
  int          m_wait_fill;
  int          m_cur;
  logic [31:0] m_now;

  sched_res_t  pending_results[$];
  int          idle_pct;
  int          stall_pct;
  int          hold_off;
  int          mismatches;
  int          cycles;

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int lookup_slot(logic [15:0] id);
    for (int s = 0; s < NSLOT; s++)
      if (m_used[s] && m_id[s] == id) return s;
    return -1;
  endfunction

  function automatic void enqueue_ready(int slot);
    if (m_ready_fill < NSLOT) begin
      m_ready_q[(m_ready_head + m_ready_fill) % NSLOT] = slot;
      m_ready_fill++;
    end
  endfunction

  // advance the mirror by one transaction and return the expected result
  function automatic sched_res_t schedule_step(logic [1:0] op, logic [15:0] id,
      logic [15:0] burst, logic [15:0] io_st, logic [15:0] io_len, logic [15:0] kill);
    sched_res_t r;
    int f;
    int s;
    int c;
    int w;
    logic [15:0] run;
    r = '0;
    if (op == OP_ADD) begin
      f = lookup_slot(id);
      if (f >= 0) r.status = ST_DUP;
      else if (burst == 0 || m_count >= NSLOT) r.status = ST_REJECT;
      else begin
        s = 0;
        while (m_used[s]) s++;
        m_used[s] = 1;
        m_id[s] = id;
        m_burst[s] = burst;
        m_io_start[s] = io_st;
        m_io_left[s] = io_len;
        m_run[s] = 0;
        m_kill[s] = 0;
        m_count++;
        enqueue_ready(s);
        r.status = ST_ADDED;
      end
    end else if (op == OP_KILL) begin
      f = lookup_slot(id);
      if (f < 0) r.status = ST_UNKNOWN;
      else begin
        m_kill[f] = kill;
        r.status = ST_KILLSET;
      end
    end else begin
      if (m_cur >= NSLOT && m_ready_fill > 0) begin
        m_cur = m_ready_q[m_ready_head];
        m_ready_head = (m_ready_head + 1) % NSLOT;
        m_ready_fill--;
      end
      if (m_cur >= NSLOT && m_ready_fill == 0 && m_wait_fill == 0) r.status = ST_IDLE;
      else begin
        r.status = ST_RAN;
        m_now++;
        if (m_cur < NSLOT) begin
          c = m_cur;
          run = m_run[c] + 16'd1;
          m_run[c] = run;
          if (m_kill[c] != 0 && run == m_kill[c]) begin
            r.done_valid = 1;
            r.done_id = m_id[c];
            r.done_killed = 1;
            r.done_time = {16'd0, run};
            m_cur = NSLOT;
          end else if (m_io_start[c] != 0 && run == m_io_start[c] && m_io_left[c] != 0) begin
            if (m_wait_fill < NSLOT) m_wait_q[m_wait_fill++] = c;
            m_cur = NSLOT;
          end else if (run >= m_burst[c]) begin
            r.done_valid = 1;
            r.done_id = m_id[c];
            r.done_time = m_now;
            r.wait_time = m_now - {16'd0, m_burst[c]};
            m_cur = NSLOT;
          end
        end
        // i/o wait list walk
        w = 0;
        for (int k = 0; k < m_wait_fill; k++) begin
          s = m_wait_q[k];
          if (m_io_left[s] == 0) enqueue_ready(s);
          else begin
            m_io_left[s]--;
            m_wait_q[w++] = s;
          end
        end
        m_wait_fill = w;
      end
    end
    if (m_cur < NSLOT) begin
      r.running_valid = 1;
      r.running_id = m_id[m_cur];
    end
    return r;
  endfunction

  // send one transaction and record its expected result
  task automatic send_item(logic [1:0] op, logic [15:0] id, logic [15:0] burst,
      logic [15:0] io_st, logic [15:0] io_len, logic [15:0] kill);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_op = op;
    in_task_id = id;
    in_burst_time = burst;
    in_io_start = io_st;
    in_io_length = io_len;
    in_kill_at = kill;
    in_valid = 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_results.push_back(schedule_step(op, id, burst, io_st, io_len, kill));
  endtask

  // receiver stalls and long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result check
  always @(posedge clk) begin
    sched_res_t exp_r;
    sched_res_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {status_t'(out_status), out_done_valid, out_done_id, out_done_killed,
             out_done_time, out_wait_time, out_running_valid, out_running_id};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: status %0d", out_status);
      end else begin
        exp_r = pending_results.pop_front();
        if (got.status !== exp_r.status || got.done_valid !== exp_r.done_valid ||
            got.done_id !== exp_r.done_id || got.done_killed !== exp_r.done_killed ||
            got.done_time !== exp_r.done_time || got.wait_time !== exp_r.wait_time ||
            got.running_valid !== exp_r.running_valid ||
            got.running_id !== exp_r.running_id) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp st%0d dv%0d id%h k%0d t%0d w%0d rv%0d rid%h / got st%0d dv%0d id%h k%0d t%0d w%0d rv%0d rid%h",
              exp_r.status, exp_r.done_valid, exp_r.done_id, exp_r.done_killed,
              exp_r.done_time, exp_r.wait_time, exp_r.running_valid, exp_r.running_id,
              got.status, got.done_valid, got.done_id, got.done_killed,
              got.done_time, got.wait_time, got.running_valid, got.running_id);
        end
      end
    end
  end

  // corner cases: idle tick, extremes, rejects, kills, i/o variants
  task automatic run_directed_cases();
    send_item(OP_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_item(OP_ADD, 16'hffff, 16'd1, 16'd0, 16'd0, 16'hffff);
    send_item(OP_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_item(OP_ADD, 16'hffff, 16'd5, 16'd0, 16'd0, 16'd0);
    send_item(OP_ADD, 16'h0001, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(OP_KILL, 16'h1234, 16'd0, 16'd0, 16'd0, 16'd9);
    send_item(OP_ADD, 16'h8000, 16'hffff, 16'hffff, 16'hffff, 16'd0);
    send_item(OP_KILL, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd3);
    send_item(OP_KILL, 16'hffff, 16'd0, 16'd0, 16'd0, 16'd7);
    send_item(OP_ADD, 16'h0002, 16'd3, 16'd1, 16'd2, 16'd0);
    send_item(OP_ADD, 16'h0003, 16'd2, 16'd2, 16'd0, 16'd0);
    send_item(OP_ADD, 16'h0004, 16'd2, 16'd2, 16'd1, 16'd0);
    send_item(OP_ADD, 16'h0000, 16'd4, 16'd0, 16'd0, 16'd0);
    send_item(OP_KILL, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd2);
    send_item(OP_KILL, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(OP_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_item(OP_ALT, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_item(OP_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_item(OP_KILL, 16'h0002, 16'd0, 16'd0, 16'd0, 16'd1);
    repeat (6) send_item(OP_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
  endtask

  // random traffic, mostly small well-formed tasks and ticks
  task automatic run_random_phase(int n, int idle_p, int stall_p, int hold);
    logic [1:0]  op;
    logic [15:0] id;
    logic [15:0] burst;
    logic [15:0] io_st;
    logic [15:0] io_len;
    logic [15:0] kill;
    int          sel;
    idle_pct = idle_p;
    stall_pct = stall_p;
    hold_off = hold;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
      burst = 16'($urandom_range(12));
      io_st = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(burst));
      io_len = 16'($urandom_range(6));
      kill = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(14));
      // table full: adds only exercise the reject and duplicate paths, so open up the fields
      if (m_count >= NSLOT) begin
        burst = 16'($urandom);
        io_st = 16'($urandom);
        io_len = 16'($urandom);
      end
      if (sel < 8) op = OP_ADD;
      else if (sel < 20) op = OP_KILL;
      else if (sel < 25) op = OP_ALT;
      else op = OP_TICK;
      // the table only fills once, so hold adds back over the run
      if (op == OP_ADD && m_count >= 10 && $urandom_range(3) != 0 && i < n - 100)
        op = OP_TICK;
      send_item(op, id, burst, io_st, io_len, kill);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_TICK;
    in_task_id = '0;
    in_burst_time = '0;
    in_io_start = '0;
    in_io_length = '0;
    in_kill_at = '0;
    out_ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_off = 0;
    mismatches = 0;
    cycles = 0;
    m_count = 0;
    m_ready_head = 0;
    m_ready_fill = 0;
    m_wait_fill = 0;
    m_cur = NSLOT;
    m_now = '0;
    for (int s = 0; s < NSLOT; s++) m_used[s] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed_cases();
    run_random_phase(400, 0, 0, 400);
    run_random_phase(400, 68, 0, 0);
    run_random_phase(400, 0, 68, 0);
    run_random_phase(400, 30, 30, 0);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
